// File: hw/rtl/rbs_pkg.sv
// shared constants and types for the ray box slab test
package rbs_pkg;
    localparam int CB = 32;                  // coordinate bits
    localparam int FB = 16;                  // fraction bits
    localparam int LANES = 3;
    localparam int DIV_LAT = CB + 2;
    localparam int LANE_LAT = DIV_LAT + 1;

    typedef logic signed [CB-1:0] coord_t;

    localparam coord_t TMAX = {1'b0, {(CB-1){1'b1}}};
    localparam coord_t TMIN = {1'b1, {(CB-1){1'b0}}};

    typedef struct packed {
        coord_t sn;
        coord_t sx;
        logic   miss;
    } slab_t;
endpackage

// File: hw/rtl/rbs_div.sv
// pipelined slab divider: (num_a - num_b) / den, truncated and saturated
module rbs_div (
    input  logic           aclk,
    input  logic           en,
    input  rbs_pkg::coord_t num_a,
    input  rbs_pkg::coord_t num_b,
    input  rbs_pkg::coord_t den,
    output rbs_pkg::coord_t quo
);
    import rbs_pkg::*;

    logic [CB:0]   nmag_reg;
    logic [CB-1:0] dmag_reg;
    logic          neg_reg;

    logic signed [CB:0] diff;
    logic signed [CB:0] dneg;

    always_comb begin
        diff = {num_a[CB-1], num_a} - {num_b[CB-1], num_b};
        dneg = -{den[CB-1], den};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nmag_reg <= diff[CB] ? (CB+1)'(-diff) : diff;
            dmag_reg <= den[CB-1] ? dneg[CB-1:0] : den;
            neg_reg  <= diff[CB] ^ den[CB-1];
        end
    end

    // step arrays, one entry per quotient bit
    logic [CB:0]   r_reg   [CB];
    logic [CB-1:0] q_reg   [CB];
    logic [CB-1:0] low_reg [CB];
    logic [CB-1:0] d_reg   [CB];
    logic          neg_s_reg [CB];
    logic          sat_reg [CB];

    logic [CB:0] r_init;
    logic        sat_init;

    always_comb begin
        // high part of the shifted numerator; at least the divisor means overflow
        r_init   = (CB+1)'(nmag_reg >> (CB - FB));
        sat_init = r_init >= {1'b0, dmag_reg};
    end

    for (genvar k = 0; k < CB; k++) begin : g_step
        logic [CB:0]   r_in;
        logic [CB-1:0] q_in;
        logic [CB-1:0] low_in;
        logic [CB-1:0] d_in;
        logic          neg_in;
        logic          sat_in;
        logic [CB:0]   t;
        logic          qb;

        if (k == 0) begin : g_first
            assign r_in   = r_init;
            assign q_in   = '0;
            assign low_in = {nmag_reg[CB-FB-1:0], {FB{1'b0}}};
            assign d_in   = dmag_reg;
            assign neg_in = neg_reg;
            assign sat_in = sat_init;
        end else begin : g_rest
            assign r_in   = r_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign low_in = low_reg[k-1];
            assign d_in   = d_reg[k-1];
            assign neg_in = neg_s_reg[k-1];
            assign sat_in = sat_reg[k-1];
        end

        always_comb begin
            t  = {r_in[CB-1:0], low_in[CB-1]};
            qb = t >= {1'b0, d_in};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k]     <= qb ? t - {1'b0, d_in} : t;
                q_reg[k]     <= {q_in[CB-2:0], qb};
                low_reg[k]   <= {low_in[CB-2:0], 1'b0};
                d_reg[k]     <= d_in;
                neg_s_reg[k] <= neg_in;
                sat_reg[k]   <= sat_in;
            end
        end
    end

    logic [CB-1:0] q_fin;
    logic [CB-1:0] lim;
    logic          sat_fin;
    coord_t        quo_next;
    coord_t        quo_reg;

    always_comb begin
        q_fin   = q_reg[CB-1];
        lim     = neg_s_reg[CB-1] ? TMIN : TMAX;
        sat_fin = sat_reg[CB-1] || (q_fin > lim);
        if (sat_fin) begin
            quo_next = neg_s_reg[CB-1] ? TMIN : TMAX;
        end else begin
            quo_next = neg_s_reg[CB-1] ? -q_fin : q_fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;
endmodule

// File: hw/rtl/rbs_lane.sv
// one axis lane: two slab divisions, containment and order checks
module rbs_lane (
    input  logic            aclk,
    input  logic            en,
    input  rbs_pkg::coord_t org,
    input  rbs_pkg::coord_t dir,
    input  rbs_pkg::coord_t lo,
    input  rbs_pkg::coord_t hi,
    output rbs_pkg::slab_t  slab
);
    import rbs_pkg::*;

    coord_t s0;
    coord_t s1;

    rbs_div u_div_lo (.aclk(aclk), .en(en), .num_a(lo), .num_b(org), .den(dir), .quo(s0));
    rbs_div u_div_hi (.aclk(aclk), .en(en), .num_a(hi), .num_b(org), .den(dir), .quo(s1));

    // flags delayed alongside the dividers
    logic dzero_reg [DIV_LAT];
    logic miss_reg  [DIV_LAT];

    always_ff @(posedge aclk) begin
        if (en) begin
            dzero_reg[0] <= dir == '0;
            miss_reg[0]  <= (lo > hi) || ((dir == '0) && ((org < lo) || (org > hi)));
            for (int i = 1; i < DIV_LAT; i++) begin
                dzero_reg[i] <= dzero_reg[i-1];
                miss_reg[i]  <= miss_reg[i-1];
            end
        end
    end

    slab_t slab_next;
    slab_t slab_reg;

    always_comb begin
        slab_next.miss = miss_reg[DIV_LAT-1];
        if (dzero_reg[DIV_LAT-1]) begin
            slab_next.sn = TMIN;
            slab_next.sx = TMAX;
        end else begin
            slab_next.sn = (s0 < s1) ? s0 : s1;
            slab_next.sx = (s0 < s1) ? s1 : s0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            slab_reg <= slab_next;
        end
    end

    assign slab = slab_reg;
endmodule

// File: hw/rtl/ray_box_slab_test_top.sv
// ray versus axis-aligned box slab test, three axis lanes and a merge stage
//
// Takes one ray and box per beat and gives one hit beat per input beat, in
// order. A new beat is accepted every cycle while the result side keeps up;
// the pipeline depth, for Q16.16 coordinates, is set by the restoring dividers,
// which produce one quotient bit per pipeline stage. The whole pipeline
// holds while a result beat waits to be taken.
module ray_box_slab_test_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  logic [12*rbs_pkg::CB-1:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit, then zero padding
    output logic [7:0]   m_tdata
);
    import rbs_pkg::*;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    slab_t slab [LANES];

    for (genvar a = 0; a < LANES; a++) begin : g_lane
        rbs_lane u_lane (
            .aclk (aclk),
            .en   (en),
            .org  (s_tdata[a*CB +: CB]),
            .dir  (s_tdata[(3+a)*CB +: CB]),
            .lo   (s_tdata[(6+a)*CB +: CB]),
            .hi   (s_tdata[(9+a)*CB +: CB]),
            .slab (slab[a])
        );
    end

    logic v_reg [LANE_LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LANE_LAT; i++) v_reg[i] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= s_tvalid;
            for (int i = 1; i < LANE_LAT; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    coord_t entry;
    coord_t exit_d;
    logic   miss;
    logic   hit_next;

    always_comb begin
        entry  = TMIN;
        exit_d = TMAX;
        miss   = 1'b0;
        for (int a = 0; a < LANES; a++) begin
            if (slab[a].sn > entry) entry = slab[a].sn;
            if (slab[a].sx < exit_d) exit_d = slab[a].sx;
            miss = miss | slab[a].miss;
        end
        hit_next = !miss && (exit_d >= entry) && (entry < TMAX) && (exit_d > 0);
    end

    logic m_tvalid_reg;
    logic hit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= v_reg[LANE_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg <= hit_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, hit_reg};

    a_ready_follows_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready)) else $error("ready not tied to output space");
    a_bubble_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && !v_reg[LANE_LAT-1]) |=> !m_tvalid) else $error("result beat invented");
    a_beat_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && v_reg[LANE_LAT-1]) |=> m_tvalid) else $error("result beat lost");
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tdata[7:1] == 7'b0) else $error("padding not zero");
endmodule

// File: tb/sv/ray_box_slab_test_top_tb.sv
// testbench for the ray versus axis-aligned box slab test
module ray_box_slab_test_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rbs_pkg::*;

    localparam int NUM_RANDOM = 900;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        coord_t org [3];
        coord_t dir [3];
        coord_t bmin [3];
        coord_t bmax [3];
    } ray_box_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [12*CB-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit expected_hits [$];
    int mismatches = 0;
    int results_seen = 0;
    int hits_seen = 0;
    int directed_count = 0;
    longint cycles = 0;

    ray_box_slab_test_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    // (num_a - num_b) / den in Q format, truncated toward zero, saturated
    function automatic longint slab_distance(longint num_a, longint num_b, longint den);
        logic signed [127:0] n;
        logic signed [127:0] q;
        n = (128'(signed'(num_a)) - 128'(signed'(num_b))) <<< FB;
        q = n / 128'(signed'(den));
        if (q > 128'(signed'(longint'(TMAX))))
            return longint'(TMAX);
        if (q < 128'(signed'(longint'(TMIN))))
            return longint'(TMIN);
        return longint'(q);
    endfunction

    function automatic bit ray_hits_box(ray_box_t r);
        longint entry_t;
        longint exit_t;
        longint s0;
        longint s1;
        bit miss;
        entry_t = longint'(TMIN);
        exit_t = longint'(TMAX);
        miss = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (r.bmin[a] > r.bmax[a]) begin
                miss = 1'b1;
                continue;
            end
            if (r.dir[a] == 0) begin
                if (r.org[a] < r.bmin[a] || r.org[a] > r.bmax[a])
                    miss = 1'b1;
                s0 = longint'(TMIN);
                s1 = longint'(TMAX);
            end else begin
                s0 = slab_distance(r.bmin[a], r.org[a], r.dir[a]);
                s1 = slab_distance(r.bmax[a], r.org[a], r.dir[a]);
                if (s0 > s1) begin
                    longint t;
                    t = s0;
                    s0 = s1;
                    s1 = t;
                end
            end
            if (s0 > entry_t)
                entry_t = s0;
            if (s1 < exit_t)
                exit_t = s1;
        end
        return !miss && exit_t >= entry_t && entry_t < longint'(TMAX) && exit_t > 0;
    endfunction

    function automatic logic [12*CB-1:0] pack_ray_box(ray_box_t r);
        logic [12*CB-1:0] v;
        for (int a = 0; a < 3; a++) begin
            v[a*CB +: CB] = r.org[a];
            v[(3+a)*CB +: CB] = r.dir[a];
            v[(6+a)*CB +: CB] = r.bmin[a];
            v[(9+a)*CB +: CB] = r.bmax[a];
        end
        return v;
    endfunction

    // valid stays high after the beat so that back-to-back calls need no second drive
    task automatic send_ray_box(ray_box_t r);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pack_ray_box(r);
        expected_hits.push_back(ray_hits_box(r));
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn)
            m_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            hits_seen += m_tdata[0];
            if (expected_hits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: hit=%0d", m_tdata[0]);
            end else begin
                bit exp_hit;
                exp_hit = expected_hits.pop_front();
                if (m_tdata[0] !== exp_hit || m_tdata[7:1] !== 7'd0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at result %0d: expected hit=%0d, got tdata=%h",
                                 results_seen, exp_hit, m_tdata);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_hits.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic coord_t rand_coord();
        case ($urandom_range(5))
            0: return coord_t'($urandom);
            1: return TMAX - coord_t'($urandom_range(3));
            2: return TMIN + coord_t'($urandom_range(3));
            3: return coord_t'(0);
            default: return coord_t'($signed($urandom_range(32'h00200000)) - 32'sh00100000);
        endcase
    endfunction

    // usually a box near the origin with a ray aimed roughly at it; some boxes inverted, some rays fully random
    function automatic ray_box_t rand_ray_box();
        ray_box_t r;
        bit shaped;
        shaped = $urandom_range(99) < 75;
        for (int a = 0; a < 3; a++) begin
            if (shaped) begin
                coord_t c;
                coord_t h;
                c = coord_t'($signed($urandom_range(32'h01000000)) - 32'sh00800000);
                h = coord_t'($urandom_range(32'h00400000));
                r.bmin[a] = c - h;
                r.bmax[a] = c + h;
                r.org[a] = c + coord_t'($signed($urandom_range(32'h02000000)) - 32'sh01000000);
                case ($urandom_range(7))
                    0: r.dir[a] = 0;
                    1: r.dir[a] = coord_t'($urandom);
                    default: r.dir[a] = (c - r.org[a]) +
                        coord_t'($signed($urandom_range(32'h00100000)) - 32'sh00080000);
                endcase
                if ($urandom_range(49) == 0) begin
                    r.bmin[a] = r.bmax[a] + 1;
                end
            end else begin
                r.org[a] = rand_coord();
                r.dir[a] = rand_coord();
                r.bmin[a] = rand_coord();
                r.bmax[a] = rand_coord();
            end
        end
        return r;
    endfunction

    function automatic ray_box_t unit_box_ray(coord_t ox, coord_t dx);
        ray_box_t r;
        for (int a = 0; a < 3; a++) begin
            r.org[a] = 0;
            r.dir[a] = 0;
            r.bmin[a] = -32'sh00010000;
            r.bmax[a] = 32'sh00010000;
        end
        r.org[0] = ox;
        r.dir[0] = dx;
        return r;
    endfunction

    task automatic test_directed();
        ray_box_t r;
        coord_t ext [6] = '{TMAX, TMIN, 0, 1, -1, 32'sh00010000};
        send_ray_box(unit_box_ray(0, 0));                   // inside, all directions zero
        send_ray_box(unit_box_ray(32'sh00050000, 0));       // outside, zero direction
        send_ray_box(unit_box_ray(32'sh00050000, -32'sh00010000));
        send_ray_box(unit_box_ray(32'sh00050000, 32'sh00010000)); // box behind
        send_ray_box(unit_box_ray(TMIN, 1));                // quotient saturates
        send_ray_box(unit_box_ray(TMAX, TMIN));
        send_ray_box(unit_box_ray(-32'sh00030000, 3));      // truncation toward zero
        r = unit_box_ray(0, 0);
        r.bmin[1] = 32'sh00020000;                          // inverted box
        send_ray_box(r);
        r = unit_box_ray(0, 32'sh00010000);
        r.bmin[2] = 0;
        r.bmax[2] = 0;                                      // flat box, origin on it
        send_ray_box(r);
        for (int i = 0; i < 12; i++) begin
            for (int a = 0; a < 3; a++) begin
                r.org[a] = ext[(i + a) % 6];
                r.dir[a] = ext[(i + 2*a + 1) % 6];
                r.bmin[a] = (i % 2) ? TMIN : ext[(i + a + 2) % 6];
                r.bmax[a] = (i % 3) ? TMAX : ext[(i + a + 3) % 6];
            end
            send_ray_box(r);
        end
        directed_count = 21;
    endtask

    task automatic test_random(int n, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < n; i++)
            send_ray_box(rand_ray_box());
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(NUM_RANDOM / 3, 17, 56);
        test_random(NUM_RANDOM / 3, 56, 17);
        test_random(NUM_RANDOM / 3, 0, 0);
        s_tvalid <= 1'b0;
        while (expected_hits.size() != 0)
            @(posedge aclk);
        repeat (2 * LANE_LAT + 10) @(posedge aclk);
        $display("%0d directed and %0d random rays checked, %0d hits among %0d results",
                 directed_count, NUM_RANDOM, hits_seen, results_seen);
        if (mismatches == 0)
            $display("RESULT: OK");
        else begin
            $display("%0d mismatches", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// File: files.f
hw/rtl/rbs_pkg.sv
hw/rtl/rbs_div.sv
hw/rtl/rbs_lane.sv
hw/rtl/ray_box_slab_test_top.sv
tb/sv/ray_box_slab_test_top_tb.sv
